// ----- rtl/slskc_pkg.sv -----
// Shared types, register indexes, sequencer states and lookup tables for the
// stereo-linked soft-knee compressor. No dependencies.
package slskc_pkg;

  // Sample width of the stereo pair
  localparam int SAMPLE_W = 16;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_SLOPE     = 3'd1;
  localparam logic [2:0] REG_KNEE      = 3'd2;
  localparam logic [2:0] REG_ATTACK    = 3'd3;
  localparam logic [2:0] REG_RELEASE   = 3'd4;
  localparam logic [2:0] REG_MAKEUP    = 3'd5;

  // dB per octave (Q16) and octaves per dB (Q24)
  localparam logic [18:0] DB_PER_OCTAVE  = 19'd394566;
  localparam logic [21:0] OCTAVES_PER_DB = 22'd2786635;

  typedef struct packed {
    logic [1:0]                 channel;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       end_of_block;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                 channel_out;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic [15:0]                applied_gain;
    logic                       end_of_block_out;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PEAK,
    S_LOG,
    S_DB,
    S_KNEE,
    S_SQR,
    S_PROD,
    S_DIV,
    S_EXP,
    S_GAIN,
    S_ENV,
    S_MAKEUP,
    S_OUT
  } seq_state_t;

  // Fractional log2 of 1 + i/16, Q16
  function automatic logic [16:0] log2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      5'd16:   v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // 2^(-i/16), Q16
  function automatic logic [16:0] exp2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/stereo_linked_soft_knee_compressor_unit.sv -----
// Stereo-linked soft-knee compressor: one stereo word in, one gain-applied word out.
// Depends on slskc_pkg for word types, register indexes, states and tables.
//
// One word is processed at a time. A word that lands inside the soft knee passes
// through the squaring, product and 13-step restoring divider of the knee
// curve on its way to the output register; a word with no knee interpolation
// skips them and goes straight on to the exponent step. The per-channel envelope sits in
// a small synchronous memory read when the word is accepted and written back
// once the follower has updated; per-entry valid bits make every envelope read
// as zero after reset with no clearing pass. The output register lets the next
// word enter while a finished word still waits downstream. Configuration writes
// are always taken (cfg_ready is tied high) and must only occur while idle.
module stereo_linked_soft_knee_compressor_unit
  import slskc_pkg::*;
#(
  parameter int NUM_CHANNELS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Configuration registers
  logic signed [15:0] threshold_level;
  logic [15:0]        slope_factor;
  logic [12:0]        knee_width;
  logic [15:0]        attack_coeff;
  logic [15:0]        release_coeff;
  logic [15:0]        makeup_gain;

  seq_state_t state, state_next;

  // Envelope store and its valid bits
  logic [15:0]             env_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] env_vld;
  logic [15:0]             env_rd;
  logic                    env_rd_vld;

  // Datapath registers
  in_word_t           item;
  logic [IDX_W-1:0]   idx;
  logic               silent;
  logic [3:0]         msb_pos;
  logic [3:0]         seg_k;
  logic [10:0]        seg_r;
  logic [19:0]        neg_oct;
  logic signed [17:0] diff_db;
  logic [13:0]        knee_u;
  logic [27:0]        knee_uu;
  logic [12:0]        div_num;
  logic [13:0]        div_rem;
  logic [12:0]        div_quo;
  logic [3:0]         div_cnt;
  logic [16:0]        reduction;
  logic [23:0]        octaves;
  logic [15:0]        target;
  logic [15:0]        nenv;
  logic [15:0]        gain;
  logic               knee_soft;

  logic [16:0] slope_om;
  logic [IDX_W-1:0] in_idx;

  assign slope_om  = 17'd65536 - {1'b0, slope_factor};
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  // Fold the channel number into the envelope store range
  always_comb begin
    logic [6:0] m;
    m = {5'd0, in_data.channel};
    for (int i = 0; i < 3; i++) begin
      if (m >= 7'(NUM_CHANNELS)) m = m - 7'(NUM_CHANNELS);
    end
    in_idx = IDX_W'(m);
  end

  // Saturating Q4.12 gain application
  function automatic logic [15:0] apply_gain(input logic signed [15:0] s,
                                             input logic [15:0] g);
    logic signed [33:0] p;
    logic signed [21:0] q;
    logic [15:0]        v;
    p = 34'(s) * $signed({18'd0, g}) + 34'sd2048;
    q = 22'(p >>> 12);
    if (q < -22'sd32768)     v = 16'h8000;
    else if (q > 22'sd32767) v = 16'h7FFF;
    else                     v = q[15:0];
    return v;
  endfunction

  // Follower update: pick coefficient, blend, round, saturate
  function automatic logic [15:0] nenv_calc();
    logic [15:0] env, c;
    logic [33:0] sum;
    env = env_rd_vld ? env_rd : 16'd0;
    c   = (target < env) ? attack_coeff : release_coeff;
    sum = 34'(c) * 34'(env) + 34'(17'd65536 - {1'b0, c}) * 34'(target) + 34'd32768;
    return (sum[33:32] != 2'd0) ? 16'hFFFF : sum[31:16];
  endfunction

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_level <= -16'sd3072;
      slope_factor    <= 16'd16384;
      knee_width      <= 13'd1536;
      attack_coeff    <= 16'd65263;
      release_coeff   <= 16'd65525;
      makeup_gain     <= 16'd4096;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD: threshold_level <= $signed(cfg_data);
        REG_SLOPE:     slope_factor    <= cfg_data;
        REG_KNEE:      knee_width      <= cfg_data[12:0];
        REG_ATTACK:    attack_coeff    <= cfg_data;
        REG_RELEASE:   release_coeff   <= cfg_data;
        REG_MAKEUP:    makeup_gain     <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Advance the sequencer
  always_comb begin
    logic signed [18:0] two_d, wn;
    two_d = {diff_db, 1'b0};
    wn    = $signed({6'd0, knee_width});
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_PEAK;
      S_PEAK:   state_next = S_LOG;
      S_LOG:    state_next = S_DB;
      S_DB:     state_next = S_KNEE;
      S_KNEE: begin
        if (two_d <= -wn || two_d >= wn) state_next = S_EXP;
        else                             state_next = S_SQR;
      end
      S_SQR:    state_next = S_PROD;
      S_PROD:   state_next = S_DIV;
      S_DIV:    if (div_cnt == 4'd0) state_next = S_EXP;
      S_EXP:    state_next = S_GAIN;
      S_GAIN:   state_next = S_ENV;
      S_ENV:    state_next = S_MAKEUP;
      S_MAKEUP: state_next = S_OUT;
      S_OUT:    if (!out_valid || !out_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Envelope memory: read on accept, write back after the follower step
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) env_rd <= env_mem[in_idx];
    if (state == S_ENV) env_mem[idx] <= nenv_calc();
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env_vld    <= '0;
      env_rd_vld <= 1'b0;
    end else begin
      if (state == S_IDLE && in_valid) env_rd_vld <= env_vld[in_idx];
      if (state == S_ENV) env_vld[idx] <= 1'b1;
    end
  end

  // Datapath steps
  always_ff @(posedge clk) begin
    logic [16:0] al, ar, peak;
    logic [15:0] mant;
    logic [3:0]  pos;
    logic [16:0] frac, lo, hi, mant_e, sh;
    logic [27:0] lp;
    logic [39:0] mp;
    logic [15:0] mag;
    logic signed [17:0] xs;
    logic signed [18:0] two_d, wn;
    logic [33:0] hp;
    logic [45:0] num;
    logic [13:0] t;
    logic [28:0] ep;
    logic [32:0] gp;
    logic [7:0]  n;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          item <= in_data;
          idx  <= in_idx;
        end
      end
      S_PEAK: begin
        al = item.left_in[15] ? 17'(-{item.left_in[15], item.left_in})
                              : {1'b0, item.left_in};
        ar = item.right_in[15] ? 17'(-{item.right_in[15], item.right_in})
                               : {1'b0, item.right_in};
        peak = (al > ar) ? al : ar;
        pos = 4'd0;
        for (int i = 0; i < 16; i++) begin
          if (peak[i]) pos = 4'(i);
        end
        mant = 16'd0;
        for (int i = 0; i < 16; i++) begin
          if (peak[i]) mant = 16'(peak << (15 - i));
        end
        msb_pos <= pos;
        silent <= (peak == 17'd0);
        seg_k  <= mant[14:11];
        seg_r  <= mant[10:0];
      end
      S_LOG: begin
        lo   = log2_tab({1'b0, seg_k});
        hi   = log2_tab(5'({1'b0, seg_k}) + 5'd1);
        lp   = 28'(hi - lo) * 28'(seg_r) + 28'd1024;
        frac = lo + 17'(lp >> 11);
        neg_oct <= {4'd15 - msb_pos, 16'd0} - 20'(frac);
      end
      S_DB: begin
        mp  = 40'(neg_oct) * 40'(DB_PER_OCTAVE) + 40'd8388608;
        mag = (mp[39:24] > 16'd32768) ? 16'd32768 : mp[39:24];
        xs  = silent ? -18'sd32768 : -$signed({2'd0, mag});
        diff_db <= xs - 18'(threshold_level);
      end
      S_KNEE: begin
        two_d = {diff_db, 1'b0};
        wn    = $signed({6'd0, knee_width});
        hp    = 34'(diff_db[16:0]) * 34'(slope_om) + 34'd32768;
        knee_u <= 14'(two_d + wn);
        if (two_d <= -wn) reduction <= 17'd0;
        else              reduction <= hp[32:16];
      end
      S_SQR: begin
        knee_uu <= 28'(knee_u) * 28'(knee_u);
      end
      S_PROD: begin
        // Quotient stays below 4096, so the top bits already sit under the divisor
        num = 46'(knee_uu) * 46'(slope_om) + (46'(knee_width) << 18);
        div_num <= num[31:19];
        div_rem <= num[45:32];
        div_quo <= '0;
        div_cnt <= 4'd12;
      end
      S_DIV: begin
        t = {div_rem[12:0], div_num[div_cnt]};
        if (t >= {1'b0, knee_width}) begin
          div_rem <= t - {1'b0, knee_width};
          div_quo <= {div_quo[11:0], 1'b1};
        end else begin
          div_rem <= t;
          div_quo <= {div_quo[11:0], 1'b0};
        end
        if (div_cnt == 4'd0) begin
          reduction <= {4'd0, div_quo[11:0], (t >= {1'b0, knee_width})};
        end
        div_cnt <= div_cnt - 4'd1;
      end
      S_EXP: begin
        mp = 40'(reduction) * 40'(OCTAVES_PER_DB) + 40'd32768;
        octaves <= mp[39:16];
      end
      S_GAIN: begin
        n      = octaves[23:16];
        lo     = exp2_tab({1'b0, octaves[15:12]});
        hi     = exp2_tab(5'({1'b0, octaves[15:12]}) + 5'd1);
        ep     = 29'(lo - hi) * 29'(octaves[11:0]) + 29'd2048;
        mant_e = lo - 17'(ep >> 12);
        sh     = mant_e >> n[4:0];
        if (n > 8'd16)     target <= 16'd0;
        else if (sh[16])   target <= 16'hFFFF;
        else               target <= sh[15:0];
      end
      S_ENV: begin
        nenv <= nenv_calc();
      end
      S_MAKEUP: begin
        gp   = 33'(nenv) * 33'(makeup_gain) + 33'd32768;
        gain <= (gp[32] != 1'b0) ? 16'hFFFF : gp[31:16];
      end
      default: ;
    endcase
  end

  // Knee path flag for the assertions
  always_ff @(posedge clk) begin
    if (rst)                  knee_soft <= 1'b0;
    else if (state == S_SQR)  knee_soft <= 1'b1;
    else if (state == S_IDLE) knee_soft <= 1'b0;
  end

  // Output register: hold until taken downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_data.channel_out      <= item.channel;
      out_data.left_out         <= $signed(apply_gain(item.left_in, gain));
      out_data.right_out        <= $signed(apply_gain(item.right_in, gain));
      out_data.applied_gain     <= gain;
      out_data.end_of_block_out <= item.end_of_block;
    end
  end

  // A new word only rises out of the output step
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("output word raised outside the output step");

  // Envelope valid bits change only on the write-back step
  a_vld_on_write: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(state) != S_ENV) |-> env_vld == $past(env_vld))
    else $error("envelope valid bits changed without a write-back");

  // Divider steps only on the soft-knee path and in range
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> (div_cnt <= 4'd12 && knee_soft))
    else $error("divider step out of range");

endmodule
